>>> sv/polygon_plane_clipper_unit_assert.svh
// Assertion helpers, sampled on the rising clock edge and disabled during reset.
`ifndef POLYGON_PLANE_CLIPPER_UNIT_ASSERT_SVH
`define POLYGON_PLANE_CLIPPER_UNIT_ASSERT_SVH

`define PPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define PPC_ASSERT_IMP(lbl, ante, cons, msg) \
  `PPC_ASSERT(lbl, (ante) |-> (cons), msg)

`define PPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  `PPC_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

>>> sv/ppc_pkg.sv
`timescale 1ns / 1ps
package ppc_pkg;

  localparam int COORD_FRAC_BITS = 16;
  localparam int T_FRAC_BITS     = 32;
  localparam int CW              = 32;
  localparam int DW              = 64;
  localparam int ACC_W           = 67;
  localparam int FRAC_W          = T_FRAC_BITS + 1;
  localparam int CNT_W           = 5;
  localparam int CFG_IDX_W       = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Z  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NEAR_GAP  = 3'd4;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_MUL, OP_SAT, OP_FIRST, OP_PREV, OP_EMIT_PREV,
    OP_GAP, OP_FRAC_HALF, OP_FRAC_ONE, OP_DIV_STEP, OP_LERP, OP_EMIT_C,
    OP_EMIT_STAT
  } dp_op_e;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_SAT, S_FIRST, S_EDGE, S_EMITV, S_GAP, S_CHK, S_DIV,
    S_LERP, S_EMITC, S_PREV, S_STAT
  } ppc_state_e;

  typedef struct packed {
    dp_op_e     op;
    logic [1:0] idx;
    logic       close;
  } ppc_cmd_t;

  typedef struct packed {
    logic prev_in;
    logic differ;
    logic last;
    logic near;
    logic rem_ge;
    logic out_free;
  } ppc_stat_t;

endpackage

>>> sv/ppc_ctrl.sv
`timescale 1ns / 1ps
module ppc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  ppc_pkg::ppc_stat_t stat_i,
  output ppc_pkg::ppc_cmd_t  cmd_o
);
  import ppc_pkg::*;

  ppc_state_e       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             close_q, close_d;
  logic             first_q, first_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      close_q <= 1'b0;
      first_q <= 1'b1;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      close_q <= close_d;
      first_q <= first_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    close_d   = close_q;
    first_d   = first_q;
    cmd_o.op  = OP_NONE;
    cmd_o.idx = cnt_q[1:0];
    cmd_o.close = close_q;
    in_stall_o = (state_q != S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          cnt_d    = '0;
          state_d  = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.op = OP_MUL;
        if (cnt_q == CNT_W'(2)) state_d = S_SAT;
        else cnt_d = cnt_q + CNT_W'(1);
      end
      S_SAT: begin
        cmd_o.op = OP_SAT;
        state_d  = first_q ? S_FIRST : S_EDGE;
      end
      S_FIRST: begin
        cmd_o.op = OP_FIRST;
        first_d  = 1'b0;
        state_d  = S_PREV;
      end
      S_EDGE: begin
        if (stat_i.prev_in) state_d = S_EMITV;
        else if (stat_i.differ) state_d = S_GAP;
        else state_d = close_q ? S_STAT : S_PREV;
      end
      S_EMITV: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_EMIT_PREV;
          if (stat_i.differ) state_d = S_GAP;
          else state_d = close_q ? S_STAT : S_PREV;
        end
      end
      S_GAP: begin
        cmd_o.op = OP_GAP;
        state_d  = S_CHK;
      end
      S_CHK: begin
        cnt_d = '0;
        if (stat_i.near) begin
          cmd_o.op = OP_FRAC_HALF;
          state_d  = S_LERP;
        end else if (stat_i.rem_ge) begin
          cmd_o.op = OP_FRAC_ONE;
          state_d  = S_LERP;
        end else begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.op = OP_DIV_STEP;
        if (cnt_q == CNT_W'(T_FRAC_BITS - 1)) begin
          cnt_d   = '0;
          state_d = S_LERP;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      S_LERP: begin
        cmd_o.op = OP_LERP;
        if (cnt_q == CNT_W'(2)) state_d = S_EMITC;
        else cnt_d = cnt_q + CNT_W'(1);
      end
      S_EMITC: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_EMIT_C;
          state_d  = close_q ? S_STAT : S_PREV;
        end
      end
      S_PREV: begin
        cmd_o.op = OP_PREV;
        if (stat_i.last) begin
          close_d = 1'b1;
          state_d = S_EDGE;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_STAT: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_EMIT_STAT;
          first_d  = 1'b1;
          close_d  = 1'b0;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

>>> sv/ppc_dp.sv
`timescale 1ns / 1ps
module ppc_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ppc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ppc_pkg::CW-1:0]        cfg_data_i,
  input  logic signed [ppc_pkg::CW-1:0] in_x_i,
  input  logic signed [ppc_pkg::CW-1:0] in_y_i,
  input  logic signed [ppc_pkg::CW-1:0] in_z_i,
  input  logic                          in_last_i,
  input  ppc_pkg::ppc_cmd_t             cmd_i,
  output ppc_pkg::ppc_stat_t            stat_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [ppc_pkg::CW-1:0] out_x_o,
  output logic signed [ppc_pkg::CW-1:0] out_y_o,
  output logic signed [ppc_pkg::CW-1:0] out_z_o,
  output logic                          vertex_valid_o,
  output logic                          polygon_end_o,
  output logic [7:0]                    out_count_o,
  output logic                          any_clipped_o
);
  import ppc_pkg::*;

  logic signed [CW-1:0] nrm_q [3];
  logic signed [CW-1:0] off_q;
  logic [CW-1:0]        gap_thr_q;

  logic signed [CW-1:0] cur_q [3];
  logic signed [CW-1:0] first_q [3];
  logic signed [CW-1:0] prev_q [3];
  logic signed [CW-1:0] res_q [3];
  logic signed [DW-1:0] cur_dist_q, first_dist_q, prev_dist_q;
  logic                 first_in_q, prev_in_q, last_q;
  logic signed [ACC_W-1:0] acc_q;
  logic [DW-1:0]        gap_q, rem_q;
  logic [FRAC_W-1:0]    frac_q;
  logic [7:0]           count_q;
  logic                 clip_q;

  logic                 out_valid_q;
  logic signed [CW-1:0] ox_q, oy_q, oz_q;
  logic                 ovv_q, oend_q, oclip_q;
  logic [7:0]           ocnt_q;

  // distance datapath
  logic signed [2*CW-1:0] prod;
  logic signed [DW-1:0]   dist_sat;
  assign prod = nrm_q[cmd_i.idx] * cur_q[cmd_i.idx];

  always_comb begin
    dist_sat = acc_q[DW-1:0];
    if (!acc_q[ACC_W-1] && (acc_q[ACC_W-2:DW-1] != '0))
      dist_sat = {1'b0, {(DW-1){1'b1}}};
    else if (acc_q[ACC_W-1] && (acc_q[ACC_W-2:DW-1] != '1))
      dist_sat = {1'b1, {(DW-1){1'b0}}};
  end

  // edge operands: v0 is always the previous vertex
  logic signed [DW-1:0] d0, d1;
  logic                 in1;
  logic [DW-1:0]        m0, m1;
  logic [DW:0]          gsum;
  logic [DW-1:0]        gap_new;
  assign d0  = prev_dist_q;
  assign d1  = cmd_i.close ? first_dist_q : cur_dist_q;
  assign in1 = cmd_i.close ? first_in_q : ~cur_dist_q[DW-1];
  assign m0  = d0[DW-1] ? DW'(-d0) : DW'(d0);
  assign m1  = d1[DW-1] ? DW'(-d1) : DW'(d1);
  assign gsum = {1'b0, m0} + {1'b0, m1};

  always_comb begin
    gap_new = gsum[DW-1:0];
    if (!d0[DW-1]) begin
      if (gsum > {2'b00, {(DW-1){1'b1}}}) gap_new = {1'b0, {(DW-1){1'b1}}};
    end else begin
      if (gsum > {2'b01, {(DW-1){1'b0}}}) gap_new = {1'b1, {(DW-1){1'b0}}};
    end
  end

  // restoring division, one quotient bit a cycle
  logic [DW:0] rem_sh;
  logic        take;
  assign rem_sh = {rem_q, 1'b0};
  assign take   = rem_sh >= {1'b0, gap_q};

  // interpolation of one coordinate
  logic signed [CW:0]     v0e, v1e, diff;
  logic [CW:0]            dmag;
  logic [CW+FRAC_W-1:0]   lprod;
  logic [CW:0]            lstep;
  logic signed [CW:0]     lres;
  assign v0e   = {prev_q[cmd_i.idx][CW-1], prev_q[cmd_i.idx]};
  assign v1e   = cmd_i.close ? {first_q[cmd_i.idx][CW-1], first_q[cmd_i.idx]}
                             : {cur_q[cmd_i.idx][CW-1], cur_q[cmd_i.idx]};
  assign diff  = v1e - v0e;
  assign dmag  = diff[CW] ? (CW+1)'(-diff) : (CW+1)'(diff);
  assign lprod = dmag * frac_q;
  assign lstep = lprod[T_FRAC_BITS +: CW+1];
  assign lres  = diff[CW] ? (v0e - $signed(lstep)) : (v0e + $signed(lstep));

  logic out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  assign stat_o.prev_in  = prev_in_q;
  assign stat_o.differ   = prev_in_q != in1;
  assign stat_o.last     = last_q;
  assign stat_o.near     = (gap_q == '0) || (gap_q < {{(DW-CW){1'b0}}, gap_thr_q});
  assign stat_o.rem_ge   = rem_q >= gap_q;
  assign stat_o.out_free = out_free;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nrm_q[0]  <= '0;
      nrm_q[1]  <= '0;
      nrm_q[2]  <= CW'(1) <<< COORD_FRAC_BITS;
      off_q     <= '0;
      gap_thr_q <= CW'(4294967);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_NORMAL_X: nrm_q[0]  <= cfg_data_i;
        CFG_NORMAL_Y: nrm_q[1]  <= cfg_data_i;
        CFG_NORMAL_Z: nrm_q[2]  <= cfg_data_i;
        CFG_OFFSET:   off_q     <= cfg_data_i;
        CFG_NEAR_GAP: gap_thr_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // control-like state: inside flags, count, clip, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_in_q  <= 1'b0;
      prev_in_q   <= 1'b0;
      count_q     <= '0;
      clip_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      case (cmd_i.op)
        OP_FIRST: first_in_q <= ~cur_dist_q[DW-1];
        OP_PREV:  prev_in_q  <= ~cur_dist_q[DW-1];
        OP_GAP:   clip_q     <= 1'b1;
        OP_EMIT_PREV, OP_EMIT_C: begin
          out_valid_q <= 1'b1;
          if (count_q != 8'hFF) count_q <= count_q + 8'd1;
        end
        OP_EMIT_STAT: begin
          out_valid_q <= 1'b1;
          count_q     <= '0;
          clip_q      <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        cur_q[0] <= in_x_i;
        cur_q[1] <= in_y_i;
        cur_q[2] <= in_z_i;
        last_q   <= in_last_i;
        acc_q    <= ACC_W'(off_q) <<< COORD_FRAC_BITS;
      end
      OP_MUL: acc_q <= acc_q + ACC_W'(prod);
      OP_SAT: cur_dist_q <= dist_sat;
      OP_FIRST: begin
        first_q      <= cur_q;
        first_dist_q <= cur_dist_q;
      end
      OP_PREV: begin
        prev_q      <= cur_q;
        prev_dist_q <= cur_dist_q;
      end
      OP_GAP: begin
        gap_q  <= gap_new;
        rem_q  <= m0;
        frac_q <= '0;
      end
      OP_FRAC_HALF: frac_q <= FRAC_W'(1) << (T_FRAC_BITS - 1);
      OP_FRAC_ONE:  frac_q <= FRAC_W'(1) << T_FRAC_BITS;
      OP_DIV_STEP: begin
        frac_q <= {frac_q[FRAC_W-2:0], take};
        rem_q  <= take ? DW'(rem_sh - {1'b0, gap_q}) : rem_sh[DW-1:0];
      end
      OP_LERP: res_q[cmd_i.idx] <= lres[CW-1:0];
      OP_EMIT_PREV: begin
        ox_q <= prev_q[0]; oy_q <= prev_q[1]; oz_q <= prev_q[2];
        ovv_q <= 1'b1; oend_q <= 1'b0; ocnt_q <= '0; oclip_q <= 1'b0;
      end
      OP_EMIT_C: begin
        ox_q <= res_q[0]; oy_q <= res_q[1]; oz_q <= res_q[2];
        ovv_q <= 1'b1; oend_q <= 1'b0; ocnt_q <= '0; oclip_q <= 1'b0;
      end
      OP_EMIT_STAT: begin
        ox_q <= '0; oy_q <= '0; oz_q <= '0;
        ovv_q <= 1'b0; oend_q <= 1'b1; ocnt_q <= count_q; oclip_q <= clip_q;
      end
      default: ;
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign out_x_o        = ox_q;
  assign out_y_o        = oy_q;
  assign out_z_o        = oz_q;
  assign vertex_valid_o = ovv_q;
  assign polygon_end_o  = oend_q;
  assign out_count_o    = ocnt_q;
  assign any_clipped_o  = oclip_q;

endmodule

>>> sv/polygon_plane_clipper_unit.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                 Payload
// vertex    in         in_valid_i / in_stall_o   in_x_i in_y_i in_z_i in_last_i
// result    out        out_valid_o / out_stall_i out_x_o out_y_o out_z_o vertex_valid_o
//                                                polygon_end_o out_count_o any_clipped_o
// config    in         cfg_we_i                  cfg_idx_i cfg_data_i
//
// One vertex at a time: each accepted request computes its plane distance and walks
// the edge from the previous vertex, if any; a crossing edge either divides with the
// bit-serial restoring divider or has its fraction forced to one half or one, then
// interpolates the crossing; the closing edge on the last vertex adds one more edge.
// The three distance products share one 32x32 multiplier.
// Reset clears the controller, inside flags, count, clip flag and output valid.
// A stalled output holds the controller in its emit state; in_stall_o stays
// high until the vertex is fully processed.
module polygon_plane_clipper_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ppc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ppc_pkg::CW-1:0]        cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [ppc_pkg::CW-1:0] in_x_i,
  input  logic signed [ppc_pkg::CW-1:0] in_y_i,
  input  logic signed [ppc_pkg::CW-1:0] in_z_i,
  input  logic                          in_last_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [ppc_pkg::CW-1:0] out_x_o,
  output logic signed [ppc_pkg::CW-1:0] out_y_o,
  output logic signed [ppc_pkg::CW-1:0] out_z_o,
  output logic                          vertex_valid_o,
  output logic                          polygon_end_o,
  output logic [7:0]                    out_count_o,
  output logic                          any_clipped_o
);
  import ppc_pkg::*;

  ppc_cmd_t  cmd;
  ppc_stat_t stat;

  // sequence each request: distance, edge checks, division, interpolation, emit
  ppc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // hold configuration, polygon state, arithmetic and the output register
  ppc_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_x_i         (in_x_i),
    .in_y_i         (in_y_i),
    .in_z_i         (in_z_i),
    .in_last_i      (in_last_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_x_o        (out_x_o),
    .out_y_o        (out_y_o),
    .out_z_o        (out_z_o),
    .vertex_valid_o (vertex_valid_o),
    .polygon_end_o  (polygon_end_o),
    .out_count_o    (out_count_o),
    .any_clipped_o  (any_clipped_o)
  );

endmodule

>>> sv/ppc_checker.sv
`timescale 1ns / 1ps
`include "polygon_plane_clipper_unit_assert.svh"
module ppc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic signed [ppc_pkg::CW-1:0] out_x_o,
  input logic signed [ppc_pkg::CW-1:0] out_y_o,
  input logic signed [ppc_pkg::CW-1:0] out_z_o,
  input logic                          vertex_valid_o,
  input logic                          polygon_end_o,
  input logic [7:0]                    out_count_o,
  input logic                          any_clipped_o
);
  import ppc_pkg::*;

  `PPC_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "result dropped")
  `PPC_ASSERT_NEXT(a_busy_after_req, in_valid_i && !in_stall_o, in_stall_o, "not busy")
  `PPC_ASSERT_IMP(a_status_zero, out_valid_o && !vertex_valid_o, polygon_end_o && out_x_o == 0 && out_y_o == 0 && out_z_o == 0, "bad status")
  `PPC_ASSERT_IMP(a_vertex_clean, out_valid_o && vertex_valid_o, !polygon_end_o && out_count_o == 0 && !any_clipped_o, "bad vertex")

endmodule

bind polygon_plane_clipper_unit ppc_checker u_ppc_checker (.*);

>>> tb/sv/tb_polygon_plane_clipper_unit.sv
`timescale 1ns / 1ps
module tb_polygon_plane_clipper_unit;
  import ppc_pkg::*;

  localparam int DRAIN_CYCLES = 300;   // worst vertex: two crossing edges plus four results
  localparam int WATCHDOG_MAX = 4000;  // covers the long receiver hold-off too
  localparam int HOLD_CYCLES  = 600;

  localparam logic signed [127:0] DIST_MAX = (128'sd1 <<< 63) - 1;
  localparam logic signed [127:0] DIST_MIN = -(128'sd1 <<< 63);

  typedef struct {
    logic signed [CW-1:0] x, y, z;
    logic                 last;
  } vertex_req_t;

  typedef struct {
    logic signed [CW-1:0] x, y, z;
    logic                 vtx;
    logic                 pend;
    logic [7:0]           cnt;
    logic                 clip;
  } clip_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = CFG_NORMAL_X;
  logic [CW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [CW-1:0] in_x_i = '0, in_y_i = '0, in_z_i = '0;
  logic in_last_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [CW-1:0] out_x_o, out_y_o, out_z_o;
  logic vertex_valid_o, polygon_end_o, any_clipped_o;
  logic [7:0] out_count_o;

  always #1 clk_i = ~clk_i;

  polygon_plane_clipper_unit u_dut (.*);

  // Plane registers as the block should hold them.
  logic signed [CW-1:0] pl_nx, pl_ny, pl_nz, pl_off;
  logic [CW-1:0] pl_gap;

  // Polygon walk state.
  logic                 want_first;
  logic signed [CW-1:0] first_v [3];
  logic                 first_in;
  logic signed [63:0]   first_d;
  logic signed [CW-1:0] prev_v [3];
  logic                 prev_in;
  logic signed [63:0]   prev_d;
  logic [7:0]           emit_cnt;
  logic                 clip_seen;

  vertex_req_t  vertex_q[$];
  clip_result_t clip_results_q[$];
  int           fail_count = 0;
  int           results_seen = 0;
  bit           tx_idle_on = 1'b1, rx_idle_on = 1'b1;

  function automatic logic signed [63:0] plane_dist(logic signed [CW-1:0] x,
                                                     logic signed [CW-1:0] y,
                                                     logic signed [CW-1:0] z);
    logic signed [127:0] acc, a, b;
    a = pl_nx; b = x; acc = a * b;
    a = pl_ny; b = y; acc = acc + a * b;
    a = pl_nz; b = z; acc = acc + a * b;
    a = pl_off; acc = acc + (a <<< COORD_FRAC_BITS);
    if (acc > DIST_MAX) return DIST_MAX[63:0];
    if (acc < DIST_MIN) return DIST_MIN[63:0];
    return acc[63:0];
  endfunction

  function automatic logic [127:0] mag64(logic signed [63:0] v);
    logic signed [127:0] w;
    w = v;
    return (w < 0) ? 128'(-w) : 128'(w);
  endfunction

  function automatic void push_vertex(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                                      logic signed [CW-1:0] z);
    clip_results_q.push_back('{x, y, z, 1'b1, 1'b0, 8'd0, 1'b0});
    if (emit_cnt != 8'd255) emit_cnt++;
  endfunction

  // Walk one edge: keep v0 if inside, then add the plane crossing if sides differ.
  function automatic void clip_edge(logic signed [CW-1:0] v0 [3], logic in0,
                                    logic signed [63:0] d0,
                                    logic signed [CW-1:0] v1 [3], logic in1,
                                    logic signed [63:0] d1);
    logic [127:0] g, r, frac, step, dm;
    logic signed [127:0] diff, res [3];
    if (in0) push_vertex(v0[0], v0[1], v0[2]);
    if (in0 == in1) return;
    clip_seen = 1'b1;
    if (d0 >= 0) begin
      g = mag64(d0) + mag64(d1);
      if (g > 128'h7FFF_FFFF_FFFF_FFFF) g = 128'h7FFF_FFFF_FFFF_FFFF;
    end else begin
      g = mag64(d0) + ((d1 < 0) ? 128'd0 : mag64(d1));
      if (g > (128'd1 << 63)) g = 128'd1 << 63;
    end
    r = mag64(d0);
    if (g == 0 || g < pl_gap) frac = 128'd1 << (T_FRAC_BITS - 1);
    else if (r >= g) frac = 128'd1 << T_FRAC_BITS;
    else frac = (r << T_FRAC_BITS) / g;
    for (int i = 0; i < 3; i++) begin
      diff = 128'(v1[i]) - 128'(v0[i]);
      dm = (diff < 0) ? 128'(-diff) : 128'(diff);
      step = (dm * frac) >> T_FRAC_BITS;
      res[i] = (diff < 0) ? 128'(v0[i]) - $signed(step) : 128'(v0[i]) + $signed(step);
    end
    push_vertex(res[0][CW-1:0], res[1][CW-1:0], res[2][CW-1:0]);
  endfunction

  function automatic void predict_clip_outputs(vertex_req_t vr);
    logic signed [CW-1:0] cur [3];
    logic signed [63:0] d;
    logic in_c;
    cur[0] = vr.x; cur[1] = vr.y; cur[2] = vr.z;
    d = plane_dist(vr.x, vr.y, vr.z);
    in_c = (d >= 0);
    if (want_first) begin
      first_v = cur; first_in = in_c; first_d = d; want_first = 1'b0;
    end else begin
      clip_edge(prev_v, prev_in, prev_d, cur, in_c, d);
    end
    prev_v = cur; prev_in = in_c; prev_d = d;
    if (vr.last) begin
      // closing edge back to the first vertex, then the status result
      clip_edge(prev_v, prev_in, prev_d, first_v, first_in, first_d);
      clip_results_q.push_back('{'0, '0, '0, 1'b0, 1'b1, emit_cnt, clip_seen});
      want_first = 1'b1; emit_cnt = '0; clip_seen = 1'b0;
    end
  endfunction

  function automatic int draw_wait(bit on);
    return on ? int'($urandom_range(0, 17)) : 0;
  endfunction

  // Driver: present vertices from the pending queue, waiting a drawn gap between them.
  int tx_gap = 0;
  always @(posedge clk_i) begin
    vertex_req_t vr;
    int g;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        vr = '{in_x_i, in_y_i, in_z_i, in_last_i};
        predict_clip_outputs(vr);
        g = draw_wait(tx_idle_on);
        if (g == 0 && vertex_q.size() > 0) begin
          vr = vertex_q.pop_front();
          in_x_i <= vr.x; in_y_i <= vr.y; in_z_i <= vr.z; in_last_i <= vr.last;
        end else begin
          in_valid_i <= 1'b0;
          tx_gap <= g;
        end
      end else if (!in_valid_i) begin
        if (tx_gap > 0) tx_gap <= tx_gap - 1;
        else if (vertex_q.size() > 0) begin
          vr = vertex_q.pop_front();
          in_x_i <= vr.x; in_y_i <= vr.y; in_z_i <= vr.z; in_last_i <= vr.last;
          in_valid_i <= 1'b1;
        end
      end
    end
  end

  // Monitor: check each accepted result, draw the receiver's stall, run the watchdog.
  int stall_left = 0, hold_left = 0, idle_cycles = 0;
  always @(posedge clk_i) begin
    clip_result_t e;
    int s;
    bit acc;
    if (rst_ni) begin
      acc = (in_valid_i && !in_stall_o);
      s = stall_left;
      if (out_valid_o && !out_stall_i) begin
        acc = 1'b1;
        results_seen++;
        if (clip_results_q.size() == 0) begin
          $error("result with nothing expected");
          fail_count++;
        end else begin
          e = clip_results_q.pop_front();
          if (out_x_o !== e.x) begin
            $error("out_x exp %0d got %0d", e.x, out_x_o); fail_count++;
          end
          if (out_y_o !== e.y) begin
            $error("out_y exp %0d got %0d", e.y, out_y_o); fail_count++;
          end
          if (out_z_o !== e.z) begin
            $error("out_z exp %0d got %0d", e.z, out_z_o); fail_count++;
          end
          if (vertex_valid_o !== e.vtx) begin
            $error("vertex_valid exp %0d got %0d", e.vtx, vertex_valid_o); fail_count++;
          end
          if (polygon_end_o !== e.pend) begin
            $error("polygon_end exp %0d got %0d", e.pend, polygon_end_o); fail_count++;
          end
          if (out_count_o !== e.cnt) begin
            $error("out_count exp %0d got %0d", e.cnt, out_count_o); fail_count++;
          end
          if (any_clipped_o !== e.clip) begin
            $error("any_clipped exp %0d got %0d", e.clip, any_clipped_o); fail_count++;
          end
        end
        s = draw_wait(rx_idle_on);
        // hold off once for a long stretch so the block backs up into its input
        if (results_seen == 40) hold_left <= HOLD_CYCLES;
      end else if (s > 0) begin
        s--;
      end
      stall_left <= s;
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= (s > 0);
      end
      idle_cycles <= acc ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_MAX) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CW-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    case (idx)
      CFG_NORMAL_X: pl_nx = val;
      CFG_NORMAL_Y: pl_ny = val;
      CFG_NORMAL_Z: pl_nz = val;
      CFG_OFFSET:   pl_off = val;
      CFG_NEAR_GAP: pl_gap = val;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    wait (vertex_q.size() == 0 && !in_valid_i);
    wait (clip_results_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
    endcase
  endfunction

  function automatic void add_vertex(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z,
                                     logic last);
    vertex_q.push_back('{x, y, z, last});
  endfunction

  // Random polygons of 1..7 vertices; now and then a stray last flag breaks one up.
  function automatic void add_polygons(int n_items);
    int len;
    while (n_items > 0) begin
      len = $urandom_range(1, 7);
      for (int i = 0; i < len; i++) begin
        add_vertex(rand_coord(), rand_coord(), rand_coord(),
                   (i == len - 1) || ($urandom_range(0, 15) == 0));
        n_items--;
      end
    end
  endfunction

  initial begin
    pl_nx = 0; pl_ny = 0; pl_nz = 32'sd65536; pl_off = 0; pl_gap = 32'd4294967;
    want_first = 1'b1; first_in = 1'b0; prev_in = 1'b0; emit_cnt = '0; clip_seen = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: single-vertex polygons, plane-touching vertex, crossings, extremes.
    tx_idle_on = 1'b0; rx_idle_on = 1'b0;
    add_vertex(32'd5, 32'd6, 32'h0001_0000, 1'b1);   // lone vertex inside
    add_vertex(32'd5, 32'd6, 32'hFFFF_0000, 1'b1);   // lone vertex outside
    add_vertex(32'd1, 32'd2, 32'd0, 1'b1);           // on the plane counts as inside
    add_vertex(32'h0001_0000, 32'd0, 32'h0002_0000, 1'b0);
    add_vertex(32'h0003_0000, 32'd0, 32'hFFFE_0000, 1'b0);
    add_vertex(32'h0000_0000, 32'h0004_0000, 32'h0001_0000, 1'b1);
    add_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    add_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    add_vertex(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
    add_vertex(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1);
    drain();
    // Near-zero gap forces the half-way crossing.
    cfg_write(CFG_NEAR_GAP, 32'hFFFF_FFFF);
    add_vertex(32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 1'b0);
    add_vertex(32'h0010_0000, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
    add_vertex(32'h7FFF_FFFF, 32'h0000_0100, 32'h0000_0003, 1'b1);
    drain();

    // Extreme plane, saturating distances.
    tx_idle_on = 1'b1; rx_idle_on = 1'b1;
    cfg_write(CFG_NORMAL_X, 32'h7FFF_FFFF);
    cfg_write(CFG_NORMAL_Y, 32'h8000_0000);
    cfg_write(CFG_NORMAL_Z, 32'hFFFF_FFFF);
    cfg_write(CFG_OFFSET,   32'h8000_0000);
    cfg_write(CFG_NEAR_GAP, 32'd0);
    add_polygons(15);
    drain();

    // Z plane again with a long alternating polygon that saturates the count.
    tx_idle_on = 1'b0; rx_idle_on = 1'b1;
    cfg_write(CFG_NORMAL_X, 32'd0);
    cfg_write(CFG_NORMAL_Y, 32'd0);
    cfg_write(CFG_NORMAL_Z, 32'h0001_0000);
    cfg_write(CFG_OFFSET,   32'd0);
    cfg_write(CFG_NEAR_GAP, $urandom_range(0, 32'h00FF_FFFF));
    for (int i = 0; i < 176; i++)
      add_vertex(rand_coord(), rand_coord(),
                 (i % 2) ? 32'h8000_0000 | $urandom_range(0, 32'h7F00_0000)
                         : 32'h0000_0000 | $urandom_range(0, 32'h7FFF_FFFF),
                 i == 175);
    drain();

    // Random plane, idles on both sides.
    tx_idle_on = 1'b1; rx_idle_on = 1'b1;
    cfg_write(CFG_NORMAL_X, $urandom());
    cfg_write(CFG_NORMAL_Y, $signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000);
    cfg_write(CFG_NORMAL_Z, $urandom());
    cfg_write(CFG_OFFSET,   $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
    cfg_write(CFG_NEAR_GAP, $urandom());
    add_polygons(15);
    drain();

    if (fail_count == 0 && clip_results_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
